// File: src/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg: shared constants and types of the lru cache hit tracker
// holds config register codes, reset values, field widths and fsm encoding
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int STAMP_W    = 32;
  localparam int OFF_W      = 4;
  localparam int IDX_W      = 3;
  localparam int NWAY_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int OUT_WAY_W  = 3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // config reset values
  localparam logic [OFF_W-1:0]  OFFSET_BITS_RST = 4'd4;
  localparam logic [IDX_W-1:0]  INDEX_BITS_RST  = 3'd6;
  localparam logic [NWAY_W-1:0] WAYS_IN_USE_RST = 4'd8;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOK   = 5'b00100,
    ST_REDUCE = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

endpackage

// File: src/slc_row_mem.sv
// ----------------------------------------------------------------------------
// slc_row_mem: single-port-write, single-port-read set memory
// one row per set, registered read data held until the next read
// ----------------------------------------------------------------------------
module slc_row_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/slc_way_search.sv
// ----------------------------------------------------------------------------
// slc_way_search: tag match and free-way search over one set
// reports the highest matching way and the highest invalid way in use
// ----------------------------------------------------------------------------
module slc_way_search #(
  parameter int WAYS  = 8,
  parameter int TAG_W = 32,
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [TAG_W-1:0] req_tag,
  input  logic [TAG_W-1:0] tags [WAYS],
  input  logic [WAYS-1:0]  valid,
  input  logic [WAYS-1:0]  active,
  output logic             hit,
  output logic [WAY_W-1:0] hit_way,
  output logic             inv,
  output logic [WAY_W-1:0] inv_way
);

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    inv     = 1'b0;
    inv_way = '0;
    // ascending scan, last one found wins
    for (int w = 0; w < WAYS; w++) begin
      if (active[w] && valid[w] && (tags[w] == req_tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (active[w] && !valid[w]) begin
        inv     = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

endmodule

// File: src/slc_lru_reduce.sv
// ----------------------------------------------------------------------------
// slc_lru_reduce: oldest-stamp search over one set
// pairwise min tree folded in place, one tree level per cycle
// ----------------------------------------------------------------------------
module slc_lru_reduce import slc_pkg::*; #(
  parameter int WAYS = 8,
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [STAMP_W-1:0] stamps [WAYS],
  input  logic [WAYS-1:0]    active,
  output logic               done,
  output logic [WAY_W-1:0]   way
);

  localparam int LVLS  = (WAYS > 1) ? $clog2(WAYS) : 0;
  localparam int PW    = 1 << LVLS;
  localparam int CNT_W = (LVLS > 0) ? $clog2(LVLS + 1) : 1;

  logic [STAMP_W-1:0] stp_r   [PW];
  logic [STAMP_W-1:0] stp_nxt [PW];
  logic [WAY_W-1:0]   way_r   [PW];
  logic [WAY_W-1:0]   way_nxt [PW];
  logic [PW-1:0]      ok_r, ok_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign done = (cnt_r == CNT_W'(LVLS));
  assign way  = way_r[0];

  always_comb begin
    stp_nxt = stp_r;
    way_nxt = way_r;
    ok_nxt  = ok_r;
    cnt_nxt = cnt_r;
    if (start) begin
      ok_nxt = '0;
      for (int i = 0; i < WAYS; i++) begin
        stp_nxt[i] = stamps[i];
        way_nxt[i] = WAY_W'(i);
        ok_nxt[i]  = active[i];
      end
      cnt_nxt = '0;
    end else if (!done) begin
      // left entry holds lower ways, so it keeps ties
      for (int i = 0; i < PW / 2; i++) begin
        if (!ok_r[2*i+1] || (ok_r[2*i] && !(stp_r[2*i+1] < stp_r[2*i]))) begin
          stp_nxt[i] = stp_r[2*i];
          way_nxt[i] = way_r[2*i];
          ok_nxt[i]  = ok_r[2*i];
        end else begin
          stp_nxt[i] = stp_r[2*i+1];
          way_nxt[i] = way_r[2*i+1];
          ok_nxt[i]  = ok_r[2*i+1];
        end
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    stp_r <= stp_nxt;
    way_r <= way_nxt;
    ok_r  <= ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(LVLS);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/set_assoc_lru_cache_hit_tracker_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_hit_tracker_core: dual tag store lru hit tracker
// ----------------------------------------------------------------------------
// one read or write access per input transaction looks up two lru tag
// stores at once: a write-through store that fills only on read misses and
// a write-back store that fills on every miss. each access returns one
// output transaction with the hit flag and the way hit or filled per store.
// input channel in_*, output channel out_*, both valid/ready. cfg_* is a
// plain write port (offset bits, index bits, ways in use), to be written
// only while the block is idle; the block itself does not enforce this.
// each store is one synchronous memory holding a whole set per row. an
// access reads its set, then compares and writes back the row when it
// hits or fills a free way; a fill that must evict walks the oldest-stamp
// tree one level per cycle between the compare and the write-back.
// after reset a clearing pass zeroes every row; in_ready is low until it
// ends. a finished result sits in the output register, so a stalled
// receiver blocks only once a second result is ready to leave.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_hit_tracker_core import slc_pkg::*; #(
  parameter int SETS      = 64,
  parameter int WAYS      = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // access input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_is_write,
  input  logic [ADDR_BITS-1:0]  in_address,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit_no_alloc,
  output logic                  out_hit_alloc,
  output logic [OUT_WAY_W-1:0]  out_way_no_alloc,
  output logic [OUT_WAY_W-1:0]  out_way_alloc,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IB_MAX_I = $clog2(SETS + 1) - 1;  // floor(log2(SETS))
  localparam logic [IDX_W-1:0] IB_LIM = IDX_W'((IB_MAX_I > 7) ? 7 : IB_MAX_I);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
  localparam int TAG_W = ADDR_BITS;
  localparam int ENT_W = TAG_W + 1 + STAMP_W;  // {tag, valid, stamp}
  localparam int ROW_W = WAYS * ENT_W;
  localparam logic [4:0] WAYS5 = 5'(WAYS);

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic [OFF_W-1:0]  off_r;
  logic [IDX_W-1:0]  idx_r;
  logic [NWAY_W-1:0] nway_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= OFFSET_BITS_RST;
      idx_r  <= INDEX_BITS_RST;
      nway_r <= WAYS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS: off_r  <= cfg_wdata;
        CFG_INDEX_BITS:  idx_r  <= cfg_wdata[IDX_W-1:0];
        CFG_WAYS_IN_USE: nway_r <= cfg_wdata;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // address split and active way mask
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]     ib;
  logic [ADDR_BITS-1:0] addr_sh;
  logic [ADDR_BITS-1:0] set_mask;
  logic [ADDR_BITS-1:0] set_full;
  logic [SET_W-1:0]     set_in;
  logic [4:0]           tag_sh;
  logic [TAG_W-1:0]     tag_in;
  logic [4:0]           nw5_raw, nw5;
  logic [WAYS-1:0]      way_act;

  // index width clipped so the set count fits the memory
  assign ib       = (idx_r > IB_LIM) ? IB_LIM : idx_r;
  assign addr_sh  = in_address >> off_r;
  assign set_mask = ~({ADDR_BITS{1'b1}} << ib);
  assign set_full = addr_sh & set_mask;
  assign set_in   = set_full[SET_W-1:0];
  assign tag_sh   = {1'b0, off_r} + {2'b00, ib};
  assign tag_in   = in_address >> tag_sh;

  // zero ways acts as one, too many acts as all
  assign nw5_raw = {1'b0, nway_r};
  assign nw5     = (nw5_raw == 5'd0) ? 5'd1 : ((nw5_raw > WAYS5) ? WAYS5 : nw5_raw);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_act[w] = (5'(w) < nw5);
    end
  end

  // --------------------------------------------------------------------------
  // control state and transaction registers
  // --------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [SET_W-1:0]   clr_cnt_r;
  logic [SET_W-1:0]   set_r;
  logic [TAG_W-1:0]   tag_r;
  logic               wr_r;
  logic [STAMP_W-1:0] acc_cnt_r;
  logic               in_acc;
  logic               clearing;
  logic               commit;
  logic               out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign clearing = (state_r == ST_CLEAR);

  // --------------------------------------------------------------------------
  // set memories, one per store
  // --------------------------------------------------------------------------
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] rd_na, rd_wa;
  logic [ROW_W-1:0] new_na, new_wa;
  logic [ROW_W-1:0] wdata_na, wdata_wa;

  assign mem_we    = clearing || commit;
  assign mem_waddr = clearing ? clr_cnt_r : set_r;
  assign wdata_na  = clearing ? '0 : new_na;
  assign wdata_wa  = clearing ? '0 : new_wa;

  slc_row_mem #(.DEPTH(SETS), .WIDTH(ROW_W)) u_na_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wdata_na),
    .re    (in_acc),
    .raddr (set_in),
    .rdata (rd_na)
  );

  slc_row_mem #(.DEPTH(SETS), .WIDTH(ROW_W)) u_wa_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wdata_wa),
    .re    (in_acc),
    .raddr (set_in),
    .rdata (rd_wa)
  );

  // row unpack; read data holds until the next accepted transaction
  logic [TAG_W-1:0]   na_tag [WAYS];
  logic [TAG_W-1:0]   wa_tag [WAYS];
  logic [STAMP_W-1:0] na_stp [WAYS];
  logic [STAMP_W-1:0] wa_stp [WAYS];
  logic [WAYS-1:0]    na_vld, wa_vld;

  for (genvar w = 0; w < WAYS; w++) begin : g_unpack
    assign na_stp[w] = rd_na[w*ENT_W +: STAMP_W];
    assign na_vld[w] = rd_na[w*ENT_W + STAMP_W];
    assign na_tag[w] = rd_na[w*ENT_W + STAMP_W + 1 +: TAG_W];
    assign wa_stp[w] = rd_wa[w*ENT_W +: STAMP_W];
    assign wa_vld[w] = rd_wa[w*ENT_W + STAMP_W];
    assign wa_tag[w] = rd_wa[w*ENT_W + STAMP_W + 1 +: TAG_W];
  end

  // --------------------------------------------------------------------------
  // tag compare and free-way search
  // --------------------------------------------------------------------------
  logic             na_hit, na_inv, wa_hit, wa_inv;
  logic [WAY_W-1:0] na_hit_way, na_inv_way, wa_hit_way, wa_inv_way;

  slc_way_search #(.WAYS(WAYS), .TAG_W(TAG_W)) u_na_search (
    .req_tag (tag_r),
    .tags    (na_tag),
    .valid   (na_vld),
    .active  (way_act),
    .hit     (na_hit),
    .hit_way (na_hit_way),
    .inv     (na_inv),
    .inv_way (na_inv_way)
  );

  slc_way_search #(.WAYS(WAYS), .TAG_W(TAG_W)) u_wa_search (
    .req_tag (tag_r),
    .tags    (wa_tag),
    .valid   (wa_vld),
    .active  (way_act),
    .hit     (wa_hit),
    .hit_way (wa_hit_way),
    .inv     (wa_inv),
    .inv_way (wa_inv_way)
  );

  // --------------------------------------------------------------------------
  // victim search by oldest stamp, only when a full set must evict
  // --------------------------------------------------------------------------
  logic             na_upd, na_fill, wa_fill;
  logic             need_lru;
  logic             lru_start, lru_done, lru_done_wa;
  logic [WAY_W-1:0] na_lru_way, wa_lru_way;

  assign na_upd    = na_hit || !wr_r;
  assign na_fill   = !na_hit && !wr_r;       // write miss: no allocate
  assign wa_fill   = !wa_hit;
  assign need_lru  = (na_fill && !na_inv) || (wa_fill && !wa_inv);
  assign lru_start = (state_r == ST_LOOK) && need_lru;

  slc_lru_reduce #(.WAYS(WAYS)) u_na_lru (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lru_start),
    .stamps (na_stp),
    .active (way_act),
    .done   (lru_done),
    .way    (na_lru_way)
  );

  // runs in lockstep with the na tree
  slc_lru_reduce #(.WAYS(WAYS)) u_wa_lru (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lru_start),
    .stamps (wa_stp),
    .active (way_act),
    .done   (lru_done_wa),
    .way    (wa_lru_way)
  );

  // --------------------------------------------------------------------------
  // way choice and row write-back
  // --------------------------------------------------------------------------
  logic [WAY_W-1:0] na_way, wa_way, na_way_out;
  logic [3:0]       na_way4, wa_way4;

  assign na_way     = na_hit ? na_hit_way : (na_inv ? na_inv_way : na_lru_way);
  assign wa_way     = wa_hit ? wa_hit_way : (wa_inv ? wa_inv_way : wa_lru_way);
  assign na_way_out = na_upd ? na_way : '0;
  assign na_way4    = 4'(na_way_out);
  assign wa_way4    = 4'(wa_way);

  always_comb begin
    new_na = rd_na;
    new_wa = rd_wa;
    for (int w = 0; w < WAYS; w++) begin
      if (na_upd && (na_way == WAY_W'(w))) begin
        new_na[w*ENT_W +: STAMP_W]  = acc_cnt_r;
        new_na[w*ENT_W + STAMP_W]   = 1'b1;
        if (na_fill) begin
          new_na[w*ENT_W + STAMP_W + 1 +: TAG_W] = tag_r;
        end
      end
      // the allocate store refreshes or fills on every access
      if (wa_way == WAY_W'(w)) begin
        new_wa[w*ENT_W +: STAMP_W]  = acc_cnt_r;
        new_wa[w*ENT_W + STAMP_W]   = 1'b1;
        if (wa_fill) begin
          new_wa[w*ENT_W + STAMP_W + 1 +: TAG_W] = tag_r;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic fin_ok;

  assign out_free = !out_valid || out_ready;
  assign fin_ok   = ((state_r == ST_LOOK) && !need_lru) ||
                    ((state_r == ST_REDUCE) && lru_done && lru_done_wa) ||
                    (state_r == ST_WRITE);
  assign commit   = fin_ok && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_SET) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end else if (need_lru) begin
          state_nxt = ST_REDUCE;
        end else begin
          state_nxt = ST_WRITE;   // receiver stalled
        end
      end
      ST_REDUCE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end else if (lru_done && lru_done_wa) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      acc_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      // stamp of this access is the incremented count
      if (in_acc) begin
        acc_cnt_r <= acc_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r <= set_in;
      tag_r <= tag_in;
      wr_r  <= in_is_write;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic                 out_valid_r;
  logic                 hit_na_r, hit_wa_r;
  logic [OUT_WAY_W-1:0] way_na_r, way_wa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit_na_r <= na_hit;
      hit_wa_r <= wa_hit;
      way_na_r <= na_way4[OUT_WAY_W-1:0];
      way_wa_r <= wa_way4[OUT_WAY_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit_no_alloc = hit_na_r;
  assign out_hit_alloc    = hit_wa_r;
  assign out_way_no_alloc = way_na_r;
  assign out_way_alloc    = way_wa_r;

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dual lru tag store hit tracker
// feeds read/write accesses through the valid/ready input channel in random
// bursts, stalls the result channel on its own pattern, and checks every
// result transaction against a cycle-free model of both tag stores. the run
// steps through several cache geometries, including out-of-range settings.
// ----------------------------------------------------------------------------
module testbench;
  import slc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SETS = 64;
  localparam int N_WAYS = 8;

  // index past the last register, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic [31:0] word_row_t [N_WAYS];
  typedef bit valid_row_t [N_WAYS];

  typedef struct packed {
    logic                 hit_na;
    logic                 hit_wa;
    logic [OUT_WAY_W-1:0] way_na;
    logic [OUT_WAY_W-1:0] way_wa;
  } hit_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: both tag stores, the access counter and the geometry,
  // plus the queue of results still owed by the block
  // --------------------------------------------------------------------------
  class hit_tracker_model;
    word_row_t   na_tag [N_SETS];
    valid_row_t  na_valid [N_SETS];
    word_row_t   na_stamp [N_SETS];
    word_row_t   wa_tag [N_SETS];
    valid_row_t  wa_valid [N_SETS];
    word_row_t   wa_stamp [N_SETS];
    logic [31:0] access_cnt;
    logic [OFF_W-1:0]  off_bits;
    logic [IDX_W-1:0]  idx_bits;
    logic [NWAY_W-1:0] ways_cfg;
    hit_result_t pending_hits[$];
    int          n_fail;

    function new();
      for (int s = 0; s < N_SETS; s++) begin
        for (int w = 0; w < N_WAYS; w++) begin
          na_tag[s][w]   = '0;
          na_valid[s][w] = 1'b0;
          na_stamp[s][w] = '0;
          wa_tag[s][w]   = '0;
          wa_valid[s][w] = 1'b0;
          wa_stamp[s][w] = '0;
        end
      end
      access_cnt = '0;
      off_bits   = OFFSET_BITS_RST;
      idx_bits   = INDEX_BITS_RST;
      ways_cfg   = WAYS_IN_USE_RST;
      n_fail     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_OFFSET_BITS: off_bits = val;
        CFG_INDEX_BITS:  idx_bits = val[IDX_W-1:0];
        CFG_WAYS_IN_USE: ways_cfg = val;
        default: ;
      endcase
    endfunction

    // index width clipped so that the sets in use fit the store
    function int eff_index_bits();
      int ib;
      ib = idx_bits;
      while (ib > 0 && (1 << ib) > N_SETS) ib--;
      return ib;
    endfunction

    function int eff_ways();
      int nw;
      nw = ways_cfg;
      if (nw < 1) nw = 1;
      if (nw > N_WAYS) nw = N_WAYS;
      return nw;
    endfunction

    // highest-numbered matching way, or -1
    function int find_way(word_row_t tags, valid_row_t valid, logic [31:0] tag, int nw);
      int hit;
      hit = -1;
      for (int w = 0; w < nw; w++)
        if (valid[w] && tags[w] == tag) hit = w;
      return hit;
    endfunction

    // highest free way first, else oldest stamp with lowest way on a tie
    function int pick_victim(valid_row_t valid, word_row_t stamps, int nw);
      int best;
      best = 0;
      for (int w = nw - 1; w >= 0; w--)
        if (!valid[w]) return w;
      for (int w = 1; w < nw; w++)
        if (stamps[w] < stamps[best]) best = w;
      return best;
    endfunction

    function void note_access(logic wr, logic [31:0] addr);
      int          ib, nw, hn, hw, wn, ww;
      int unsigned set_idx;
      logic [63:0] wide;
      logic [31:0] tag;
      hit_result_t exp_res;
      ib      = eff_index_bits();
      nw      = eff_ways();
      wide    = {32'd0, addr};
      set_idx = int'((wide >> off_bits) & ((64'd1 << ib) - 64'd1));
      tag     = 32'(wide >> (off_bits + ib));
      access_cnt = access_cnt + 32'd1;

      hn = find_way(na_tag[set_idx], na_valid[set_idx], tag, nw);
      hw = find_way(wa_tag[set_idx], wa_valid[set_idx], tag, nw);

      // write-through store: refresh on hit, fill on read miss only
      wn = 0;
      if (hn >= 0) begin
        na_stamp[set_idx][hn] = access_cnt;
        wn = hn;
      end else if (!wr) begin
        wn = pick_victim(na_valid[set_idx], na_stamp[set_idx], nw);
        na_tag[set_idx][wn]   = tag;
        na_valid[set_idx][wn] = 1'b1;
        na_stamp[set_idx][wn] = access_cnt;
      end

      // write-back store: fill on every miss
      if (hw >= 0) begin
        ww = hw;
      end else begin
        ww = pick_victim(wa_valid[set_idx], wa_stamp[set_idx], nw);
        wa_tag[set_idx][ww]   = tag;
        wa_valid[set_idx][ww] = 1'b1;
      end
      wa_stamp[set_idx][ww] = access_cnt;

      exp_res.hit_na = (hn >= 0);
      exp_res.hit_wa = (hw >= 0);
      exp_res.way_na = OUT_WAY_W'(wn);
      exp_res.way_wa = OUT_WAY_W'(ww);
      pending_hits.push_back(exp_res);
    endfunction

    function void check_result(hit_result_t got);
      hit_result_t exp_res;
      if (pending_hits.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result: hit_na=%0d hit_wa=%0d way_na=%0d way_wa=%0d",
                   got.hit_na, got.hit_wa, got.way_na, got.way_wa);
        return;
      end
      exp_res = pending_hits.pop_front();
      if (got.hit_na !== exp_res.hit_na || got.hit_wa !== exp_res.hit_wa ||
          got.way_na !== exp_res.way_na || got.way_wa !== exp_res.way_wa) begin
        n_fail++;
        if (n_fail <= 10)
          $display("mismatch: exp hit_na=%0d hit_wa=%0d way_na=%0d way_wa=%0d, got %0d %0d %0d %0d",
                   exp_res.hit_na, exp_res.hit_wa, exp_res.way_na, exp_res.way_wa,
                   got.hit_na, got.hit_wa, got.way_na, got.way_wa);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block hookup
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_is_write;
  logic [31:0]           in_address;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_hit_no_alloc;
  logic                  out_hit_alloc;
  logic [OUT_WAY_W-1:0]  out_way_no_alloc;
  logic [OUT_WAY_W-1:0]  out_way_alloc;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  set_assoc_lru_cache_hit_tracker_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_is_write      (in_is_write),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit_no_alloc (out_hit_no_alloc),
    .out_hit_alloc    (out_hit_alloc),
    .out_way_no_alloc (out_way_no_alloc),
    .out_way_alloc    (out_way_alloc),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  hit_tracker_model model = new();

  // recently sent addresses, reused to provoke hits
  logic [31:0] recent[$];
  // transactions left in the current sender burst
  int          burst_left = 0;
  // free-running cycle count, drives the receiver stall pattern
  int unsigned cyc = 0;
  int          ready_run = 0;

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // result side: check each accepted transaction, then pick the next ready.
  // while bit 9 of the cycle count is set, ready is held high; otherwise
  // ready alternates between high and low runs of random length
  always @(posedge clk) begin
    logic nxt_ready;
    cyc <= cyc + 1;
    if (rst_n && out_valid && out_ready)
      model.check_result({out_hit_no_alloc, out_hit_alloc, out_way_no_alloc, out_way_alloc});
    nxt_ready = out_ready;
    if (cyc[9]) begin
      nxt_ready = 1'b1;
    end else if (ready_run <= 0) begin
      if ($urandom_range(0, 99) < 60) begin
        nxt_ready = 1'b1;
        ready_run = $urandom_range(1, 20);
      end else begin
        nxt_ready = 1'b0;
        ready_run = $urandom_range(1, 15);
      end
    end else begin
      ready_run--;
    end
    out_ready <= nxt_ready;
  end

  // one access transaction; opens a new burst after a random gap when the
  // current one is used up, and returns at the edge where it is taken
  task automatic issue(input logic wr, input logic [31:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid   <= 1'b0;
        in_address <= $urandom;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_is_write <= wr;
    in_address  <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model.note_access(wr, addr);
  endtask

  // wait until every owed result is back, then let the block finish
  // any write-back still in progress
  task automatic settle();
    in_valid <= 1'b0;
    while (model.pending_hits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // write all registers back to back while idle, plus the unused index
  task automatic apply_config(input logic [CFG_DATA_W-1:0] off_v,
                              input logic [CFG_DATA_W-1:0] idx_v,
                              input logic [CFG_DATA_W-1:0] ways_v);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = CFG_DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OFFSET_BITS;
    cfg_wdata <= off_v;
    @(posedge clk);
    cfg_index <= CFG_INDEX_BITS;
    cfg_wdata <= idx_v;
    @(posedge clk);
    cfg_index <= CFG_WAYS_IN_USE;
    cfg_wdata <= ways_v;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.write_reg(CFG_OFFSET_BITS, off_v);
    model.write_reg(CFG_INDEX_BITS, idx_v);
    model.write_reg(CFG_WAYS_IN_USE, ways_v);
    model.write_reg(CFG_UNUSED, junk);
  endtask

  // random accesses shaped to the current geometry: most land on a few hot
  // sets with a handful of tags more than the ways in use, so hits, fills
  // and evictions all happen; the rest reuse recent addresses or are noise
  task automatic random_accesses(input int n);
    logic [31:0] base, addr, offmask, t;
    logic [5:0]  hot [4];
    int          shift, ib, nw, k, r;
    ib      = model.eff_index_bits();
    nw      = model.eff_ways();
    shift   = model.off_bits + ib;
    offmask = (32'd1 << model.off_bits) - 32'd1;
    base    = $urandom;
    foreach (hot[i]) hot[i] = 6'($urandom_range(0, (1 << ib) - 1));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        addr = $urandom;
      end else if (r < 30 && recent.size() > 0) begin
        addr = recent[$urandom_range(0, recent.size() - 1)] ^ ($urandom & offmask);
      end else begin
        k    = $urandom_range(0, nw + 2);
        t    = base + 32'(k);
        addr = (t << shift) | (32'(hot[$urandom_range(0, 3)]) << model.off_bits) |
               ($urandom & offmask);
      end
      recent.push_back(addr);
      if (recent.size() > 32) void'(recent.pop_front());
      issue($urandom_range(0, 99) < 35, addr);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_is_write <= 1'b0;
    in_address  <= '0;
    out_ready   <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_OFFSET_BITS;
    cfg_wdata   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: 16-byte blocks, 64 sets, 8 ways
    issue(1'b0, 32'h0000_0000);   // cold read miss, both stores fill
    issue(1'b0, 32'h0000_0008);   // same block, both hit
    issue(1'b1, 32'hFFFF_FFF0);   // write miss: only the write-back store fills
    issue(1'b0, 32'hFFFF_FFFF);   // read: write-through fills, write-back hits
    issue(1'b1, 32'hFFFF_FFFF);   // write hit in both
    // fill one set with eight tags, touch the first, then force an eviction
    for (int i = 1; i <= 8; i++) issue(1'b0, 32'(i) << 10);
    issue(1'b0, 32'h0000_0400);
    issue(1'b1, 32'h0000_2400);
    random_accesses(150);

    // index too wide, two ways: a fill lands in way 1
    apply_config(4'd0, 4'd7, 4'd2);
    issue(1'b0, 32'h0000_0125);
    // one way: way 1 drops out of the search, the same tag fills way 0
    apply_config(4'd0, 4'd7, 4'd1);
    issue(1'b0, 32'h0000_0125);
    // two ways again: duplicate tags, the higher way wins
    apply_config(4'd0, 4'd7, 4'd2);
    issue(1'b0, 32'h0000_0125);
    issue(1'b1, 32'h0000_0125);
    random_accesses(100);

    // largest offset, single set, zero ways acting as one
    apply_config(4'd15, 4'd0, 4'd0);
    issue(1'b0, 32'hFFFF_FFFF);
    issue(1'b0, 32'h0000_0000);
    random_accesses(100);

    // ways above the store size act as the full store
    apply_config(4'd12, 4'd6, 4'd15);
    random_accesses(100);

    repeat (6) begin
      apply_config(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)),
                   CFG_DATA_W'($urandom_range(0, 15)));
      random_accesses(100);
    end

    settle();
    repeat (10) @(posedge clk);
    if (model.n_fail == 0 && model.pending_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
